// ----- rtl/cfd_pkg.sv -----
// Shared types and constants of the CRC-16 checked frame deframer.
// Used by cfd_crc16, cfd_parser and crc16_checked_frame_deframer.
`default_nettype none
package cfd_pkg;

  // Head bytes of a frame
  localparam logic [7:0] HEAD_FIRST  = 8'hA5;
  localparam logic [7:0] HEAD_SECOND = 8'h5A;

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Bytes to discard after a bad version or a length over the limit
  localparam logic [3:0] SKIP_AFTER_VER = 4'd8;
  localparam logic [3:0] SKIP_AFTER_LEN = 4'd2;

  // Result kinds
  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_BAD_VER  = 3'd2;
  localparam logic [2:0] KIND_LEN_OVER = 3'd3;
  localparam logic [2:0] KIND_CRC_FAIL = 3'd4;
  localparam logic [2:0] KIND_NOISE    = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_VERSION = 2'd0;
  localparam logic [1:0] CFG_IDX_MAX_LEN = 2'd1;

  // Parser phases, one-hot
  typedef enum logic [11:0] {
    PH_HUNT    = 12'b0000_0000_0001,
    PH_VER     = 12'b0000_0000_0010,
    PH_TYPE    = 12'b0000_0000_0100,
    PH_SEQLO   = 12'b0000_0000_1000,
    PH_SEQHI   = 12'b0000_0001_0000,
    PH_CMD     = 12'b0000_0010_0000,
    PH_LENLO   = 12'b0000_0100_0000,
    PH_LENHI   = 12'b0000_1000_0000,
    PH_PAYLOAD = 12'b0001_0000_0000,
    PH_CRCLO   = 12'b0010_0000_0000,
    PH_CRCHI   = 12'b0100_0000_0000,
    PH_SKIP    = 12'b1000_0000_0000
  } phase_t;

  // One result from the parser
  typedef struct packed {
    logic        emit;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [15:0] sequence_res;
    logic [7:0]  command;
    logic [15:0] payload_len;
    logic [15:0] noise_count;
  } cfd_res_t;

endpackage
`default_nettype wire

// ----- rtl/cfd_crc16.sv -----
// Byte-wide CRC-16/MODBUS update (reflected polynomial), unrolled over 8 bits.
// Depends on cfd_pkg for the polynomial.
`default_nettype none
module cfd_crc16 (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);

  // Fold in the byte, then shift out eight bits
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ cfd_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

// ----- rtl/cfd_parser.sv -----
// Frame parser: head hunt, header fields, payload pass-through, CRC check.
// Depends on cfd_pkg and cfd_crc16.
`default_nettype none
module cfd_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [7:0]          expected_version,
  input  wire logic [15:0]         max_payload_len,
  output cfd_pkg::cfd_res_t        res
);

  cfd_pkg::phase_t phase_r, phase_nxt;
  logic        saw_head_r, saw_head_nxt;
  logic [15:0] dropped_r, dropped_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [3:0]  skip_r, skip_nxt;

  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] seen_inc;
  logic [15:0] drop_one;
  logic [3:0]  skip_dec;
  logic [15:0] dropped_upd;

  cfd_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign len_full = {rx_byte, len_r[7:0]};
  assign seen_inc = seen_r + 16'd1;
  assign skip_dec = (skip_r != 4'd0) ? skip_r - 4'd1 : skip_r;

  // Saturating drop count: the pending A5 and the current byte may both drop
  always_comb begin
    drop_one = dropped_r;
    if (saw_head_r && drop_one != 16'hFFFF) begin
      drop_one = drop_one + 16'd1;
    end
    dropped_nxt = drop_one;
    if (rx_byte != cfd_pkg::HEAD_FIRST && drop_one != 16'hFFFF) begin
      dropped_nxt = drop_one + 16'd1;
    end
  end

  // Next state and result for one byte
  always_comb begin
    logic [15:0] drop_keep;
    logic [2:0]  kind;
    logic        emit;
    logic [7:0]  dbyte;
    logic [15:0] noise;
    drop_keep    = dropped_r;
    phase_nxt    = phase_r;
    saw_head_nxt = saw_head_r;
    type_nxt     = type_r;
    seq_nxt      = seq_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    seen_nxt     = seen_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    skip_nxt     = skip_r;
    emit         = 1'b0;
    kind         = cfd_pkg::KIND_PAYLOAD;
    dbyte        = 8'h00;
    noise        = 16'h0000;
    case (phase_r)
      cfd_pkg::PH_VER: begin
        crc_nxt = crc_upd;
        if (rx_byte != expected_version) begin
          skip_nxt  = cfd_pkg::SKIP_AFTER_VER;
          phase_nxt = cfd_pkg::PH_SKIP;
          emit      = 1'b1;
          kind      = cfd_pkg::KIND_BAD_VER;
        end else begin
          phase_nxt = cfd_pkg::PH_TYPE;
        end
      end
      cfd_pkg::PH_TYPE: begin
        crc_nxt   = crc_upd;
        type_nxt  = rx_byte;
        phase_nxt = cfd_pkg::PH_SEQLO;
      end
      cfd_pkg::PH_SEQLO: begin
        crc_nxt   = crc_upd;
        seq_nxt   = {8'h00, rx_byte};
        phase_nxt = cfd_pkg::PH_SEQHI;
      end
      cfd_pkg::PH_SEQHI: begin
        crc_nxt   = crc_upd;
        seq_nxt   = {rx_byte, seq_r[7:0]};
        phase_nxt = cfd_pkg::PH_CMD;
      end
      cfd_pkg::PH_CMD: begin
        crc_nxt   = crc_upd;
        cmd_nxt   = rx_byte;
        phase_nxt = cfd_pkg::PH_LENLO;
      end
      cfd_pkg::PH_LENLO: begin
        crc_nxt   = crc_upd;
        len_nxt   = {8'h00, rx_byte};
        phase_nxt = cfd_pkg::PH_LENHI;
      end
      cfd_pkg::PH_LENHI: begin
        crc_nxt = crc_upd;
        len_nxt = len_full;
        if (len_full > max_payload_len) begin
          skip_nxt  = cfd_pkg::SKIP_AFTER_LEN;
          phase_nxt = cfd_pkg::PH_SKIP;
          emit      = 1'b1;
          kind      = cfd_pkg::KIND_LEN_OVER;
        end else begin
          seen_nxt  = 16'h0000;
          phase_nxt = (len_full == 16'h0000) ? cfd_pkg::PH_CRCLO : cfd_pkg::PH_PAYLOAD;
        end
      end
      cfd_pkg::PH_PAYLOAD: begin
        crc_nxt  = crc_upd;
        seen_nxt = seen_inc;
        if (seen_inc >= len_r) begin
          phase_nxt = cfd_pkg::PH_CRCLO;
        end
        emit  = 1'b1;
        kind  = cfd_pkg::KIND_PAYLOAD;
        dbyte = rx_byte;
      end
      cfd_pkg::PH_CRCLO: begin
        crc_lo_nxt = rx_byte;
        phase_nxt  = cfd_pkg::PH_CRCHI;
      end
      cfd_pkg::PH_CRCHI: begin
        phase_nxt    = cfd_pkg::PH_HUNT;
        saw_head_nxt = 1'b0;
        emit         = 1'b1;
        kind         = ({rx_byte, crc_lo_r} == crc_r) ? cfd_pkg::KIND_GOOD
                                                      : cfd_pkg::KIND_CRC_FAIL;
      end
      cfd_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 4'd0) begin
          phase_nxt    = cfd_pkg::PH_HUNT;
          saw_head_nxt = 1'b0;
        end
      end
      default: begin
        // Hunt for A5 5A; unknown phase codes land here too
        phase_nxt = cfd_pkg::PH_HUNT;
        if (saw_head_r && rx_byte == cfd_pkg::HEAD_SECOND) begin
          saw_head_nxt = 1'b0;
          drop_keep    = 16'h0000;
          type_nxt     = 8'h00;
          seq_nxt      = 16'h0000;
          cmd_nxt      = 8'h00;
          len_nxt      = 16'h0000;
          seen_nxt     = 16'h0000;
          crc_nxt      = cfd_pkg::CRC_INIT;
          crc_lo_nxt   = 8'h00;
          phase_nxt    = cfd_pkg::PH_VER;
          emit         = (dropped_r != 16'h0000);
          kind         = cfd_pkg::KIND_NOISE;
          noise        = dropped_r;
        end else begin
          drop_keep    = dropped_nxt;
          saw_head_nxt = (rx_byte == cfd_pkg::HEAD_FIRST);
        end
      end
    endcase
    res.emit         = emit;
    res.kind         = kind;
    res.data_byte    = dbyte;
    res.frame_type   = type_nxt;
    res.sequence_res = seq_nxt;
    res.command      = cmd_nxt;
    res.payload_len  = len_nxt;
    res.noise_count  = noise;
    dropped_upd      = drop_keep;
  end

  // Advance state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= cfd_pkg::PH_HUNT;
      saw_head_r <= 1'b0;
      dropped_r  <= 16'h0000;
      type_r     <= 8'h00;
      seq_r      <= 16'h0000;
      cmd_r      <= 8'h00;
      len_r      <= 16'h0000;
      seen_r     <= 16'h0000;
      crc_r      <= cfd_pkg::CRC_INIT;
      crc_lo_r   <= 8'h00;
      skip_r     <= 4'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      saw_head_r <= saw_head_nxt;
      dropped_r  <= dropped_upd;
      type_r     <= type_nxt;
      seq_r      <= seq_nxt;
      cmd_r      <= cmd_nxt;
      len_r      <= len_nxt;
      seen_r     <= seen_nxt;
      crc_r      <= crc_nxt;
      crc_lo_r   <= crc_lo_nxt;
      skip_r     <= skip_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/crc16_checked_frame_deframer.sv -----
// Top level of the CRC-16/MODBUS checked frame deframer: input register,
// configuration registers, parser and result register. Depends on cfd_pkg, cfd_parser.
//
//   Channel   Ports                                   Direction  Content
//   input     in_valid/in_ready, in_rx_byte           in         one link byte
//   result    out_valid/out_ready, out_kind ...       out        zero or one per byte
//   config    cfg_valid/cfg_ready, cfg_index/cfg_data in         0 version, 1 length limit
//
// One byte per cycle unless a stalled result holds the parser; while a byte sits in the input
// register the parser and CRC update act on it, and the result register loads when it steps.
// From input transfer to result valid a byte passes the input register, then the result register.
// rst_n is synchronous: parser hunts for a head, limits go to version 1 and length 1024.
// A stalled result holds the parser; the input register then fills and drops in_ready.
`default_nettype none
module crc16_checked_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_frame_type,
  output logic [15:0]      out_sequence_res,
  output logic [7:0]       out_command,
  output logic [15:0]      out_payload_len,
  output logic [15:0]      out_noise_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic        byte_vld_r;
  logic [7:0]  byte_r;
  logic [7:0]  ver_r;
  logic [15:0] max_len_r;
  logic        out_vld_r;
  cfd_pkg::cfd_res_t res;
  cfd_pkg::cfd_res_t res_r;
  logic        step;

  // Process the held byte when the result register is free or draining
  assign step      = byte_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !byte_vld_r || step;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_ready) begin
      byte_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r     <= 8'd1;
      max_len_r <= 16'd1024;
    end else if (cfg_valid) begin
      if (cfg_index == cfd_pkg::CFG_IDX_VERSION) begin
        ver_r <= cfg_data[7:0];
      end
      if (cfg_index == cfd_pkg::CFG_IDX_MAX_LEN) begin
        max_len_r <= cfg_data;
      end
    end
  end

  cfd_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .rx_byte          (byte_r),
    .expected_version (ver_r),
    .max_payload_len  (max_len_r),
    .res              (res)
  );

  // Result register: load on an emitting step, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && res.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = res_r.kind;
  assign out_data_byte    = res_r.data_byte;
  assign out_frame_type   = res_r.frame_type;
  assign out_sequence_res = res_r.sequence_res;
  assign out_command      = res_r.command;
  assign out_payload_len  = res_r.payload_len;
  assign out_noise_count  = res_r.noise_count;

endmodule
`default_nettype wire
